// ===== rtl/scc_pkg.sv =====
// scc_pkg: shared types and constants for the selective cosine correlation block
// no dependencies
package scc_pkg;

	localparam int SumW = 48;
	localparam int CntW = 17;

	typedef enum logic [1:0] {
		MODE_ALL = 2'd0,
		MODE_POS = 2'd1,
		MODE_NEG = 2'd2,
		MODE_ALT = 2'd3
	} mode_t;

	typedef struct packed {
		logic signed [15:0] sample_x;
		logic signed [15:0] sample_y;
		logic               last_sample;
	} in_beat_t;

	typedef struct packed {
		logic signed [15:0] coefficient;
		logic               empty_selection;
	} out_beat_t;

	// finished vector sums handed from front to back
	typedef struct packed {
		logic signed [SumW-1:0] dot;
		logic [SumW-1:0]        xx;
		logic [SumW-1:0]        yy;
		logic                   empty;
	} job_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_SRCH,
		ST_CMP,
		ST_DONE
	} bk_state_t;

endpackage

// ===== rtl/selective_cosine_correlation.sv =====
// selective_cosine_correlation: top level, front accumulator, queue, ratio back end
// depends on scc_pkg, scc_front, scc_queue, scc_back
//
// channel   dir  payload               handshake
// in        in   scc_pkg::in_beat_t    in_valid / in_stall
// out       out  scc_pkg::out_beat_t   out_valid / out_stall
// cfg       in   select_mode[1:0]      cfg_we
//
// the front takes one beat a cycle while no finished job waits; one product stage then the accumulators
// the back end forms its 48x48 products in a shared 24x24 multiplier
// (and skips the products and search when the selection is empty or a denominator is zero)
// a two-entry queue lets short vectors pile up while the back end works
// reset clears sums, queue and mode; stalls back up through the queue to the input
module selective_cosine_correlation #(
	parameter int MAX_SAMPLES = 65536
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_wdata,
	input  logic               in_valid,
	output logic               in_stall,
	input  scc_pkg::in_beat_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output scc_pkg::out_beat_t out_data
);

	localparam int Cap = (MAX_SAMPLES < 65536) ? MAX_SAMPLES : 65536;

	logic [1:0]    mode_q;
	logic          fj_valid, fj_stall, bj_valid, bj_stall;
	scc_pkg::job_t fj_data, bj_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)     mode_q <= 2'd0;
		else if (cfg_we) mode_q <= cfg_wdata;
	end

	scc_front #(.CAP(Cap)) u_front (
		.clk, .arst_n, .select_mode(mode_q), .in_valid, .in_stall, .in_data,
		.job_valid(fj_valid), .job_stall(fj_stall), .job_data(fj_data)
	);

	scc_queue u_queue (
		.clk, .arst_n, .wr_valid(fj_valid), .wr_stall(fj_stall), .wr_data(fj_data),
		.rd_valid(bj_valid), .rd_stall(bj_stall), .rd_data(bj_data)
	);

	scc_back u_back (
		.clk, .arst_n, .job_valid(bj_valid), .job_stall(bj_stall), .job_data(bj_data),
		.out_valid, .out_stall, .out_data
	);

endmodule

// ===== rtl/scc_front.sv =====
// scc_front: mode filter and one-pair-per-cycle accumulation while no finished job waits
// depends on scc_pkg
module scc_front #(
	parameter int CAP = 65536
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [1:0]        select_mode,
	input  logic              in_valid,
	output logic              in_stall,
	input  scc_pkg::in_beat_t in_data,
	output logic              job_valid,
	input  logic              job_stall,
	output scc_pkg::job_t     job_data
);

	logic signed [scc_pkg::SumW-1:0] dot_q;
	logic [scc_pkg::SumW-1:0]        xx_q, yy_q;
	logic [scc_pkg::CntW-1:0]        cnt_q;
	logic signed [31:0]              pxy_s1;
	logic [31:0]                     pxx_s1, pyy_s1;
	logic                            adm_s1, last_s1, v_s1;
	logic                            admit, take;
	logic signed [scc_pkg::SumW-1:0] dot_n;
	logic [scc_pkg::SumW-1:0]        xx_n, yy_n;
	logic [scc_pkg::CntW-1:0]        cnt_n;

	// hold off while a finished job waits
	assign in_stall = job_valid && job_stall;
	assign take = in_valid && !in_stall;

	// mode filter
	always_comb begin
		case (scc_pkg::mode_t'(select_mode))
			scc_pkg::MODE_POS: admit = !in_data.sample_x[15] && (in_data.sample_x != 16'sd0);
			scc_pkg::MODE_NEG: admit = in_data.sample_x[15];
			default:           admit = 1'b1;
		endcase
	end

	// stage 1: products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!in_stall) begin
			v_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			pxy_s1  <= in_data.sample_x * in_data.sample_y;
			pxx_s1  <= 32'(in_data.sample_x * in_data.sample_x);
			pyy_s1  <= 32'(in_data.sample_y * in_data.sample_y);
			adm_s1  <= admit;
			last_s1 <= in_data.last_sample;
		end
	end

	// stage 2: accumulate with sample cap
	always_comb begin
		dot_n = dot_q;
		xx_n  = xx_q;
		yy_n  = yy_q;
		cnt_n = cnt_q;
		if (adm_s1 && (cnt_q < scc_pkg::CntW'(CAP))) begin
			dot_n = dot_q + scc_pkg::SumW'(pxy_s1);
			xx_n  = xx_q + scc_pkg::SumW'(pxx_s1);
			yy_n  = yy_q + scc_pkg::SumW'(pyy_s1);
			cnt_n = cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_q     <= '0;
			xx_q      <= '0;
			yy_q      <= '0;
			cnt_q     <= '0;
			job_valid <= 1'b0;
		end else begin
			// job stays while stalled, a last pair raises a new one
			job_valid <= (job_valid && job_stall) || (v_s1 && !in_stall && last_s1);
			if (v_s1 && !in_stall) begin
				if (last_s1) begin
					dot_q     <= '0;
					xx_q      <= '0;
					yy_q      <= '0;
					cnt_q     <= '0;
				end else begin
					dot_q <= dot_n;
					xx_q  <= xx_n;
					yy_q  <= yy_n;
					cnt_q <= cnt_n;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1 && !in_stall && last_s1) begin
			job_data.dot   <= dot_n;
			job_data.xx    <= xx_n;
			job_data.yy    <= yy_n;
			job_data.empty <= (cnt_n == '0);
		end
	end

endmodule

// ===== rtl/scc_queue.sv =====
// scc_queue: two-entry job queue between front and back
// depends on scc_pkg
module scc_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_valid,
	output logic          wr_stall,
	input  scc_pkg::job_t wr_data,
	output logic          rd_valid,
	input  logic          rd_stall,
	output scc_pkg::job_t rd_data
);

	scc_pkg::job_t mem_q [2];
	logic          wp_q, rp_q;
	logic [1:0]    cnt_q;
	logic          wr, rd;

	assign wr_stall = (cnt_q == 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_data  = mem_q[rp_q];
	assign wr = wr_valid && !wr_stall;
	assign rd = rd_valid && !rd_stall;

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end

	// pointers and fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) wp_q <= !wp_q;
			if (rd) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(wr) - 2'(rd);
		end
	end

endmodule

// ===== rtl/scc_back.sv =====
// scc_back: exact ratio by bit search, 32768*|dot|/sqrt(xx*yy), halves up
// depends on scc_pkg
module scc_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               job_valid,
	output logic               job_stall,
	input  scc_pkg::job_t      job_data,
	output logic               out_valid,
	input  logic               out_stall,
	output scc_pkg::out_beat_t out_data
);

	// rhs = mag^2 * 2^32 (<=127 bits); xy = xx*yy (<=96 bits)
	// the 48x48 multiplies are done 24x24 bit per cycle over a shared unit
	scc_pkg::bk_state_t st_q, st_n;
	logic [47:0]  mag_q, xx_q, yy_q;
	logic         neg_q, zero_q, empty_q;
	logic [95:0]  mm_q, xy_q;
	logic [127:0] lhs_q;
	logic [15:0]  res_q;
	logic [3:0]   step_q;
	logic [2:0]   pp_q;
	logic [4:0]   bit_q;
	logic [47:0]  ma, mb;
	logic [23:0]  fa, fb;
	logic [47:0]  fp;
	logic [95:0]  acc_q;
	logic [16:0]  cand;
	logic [16:0]  k_n;
	logic [33:0]  kk_q;

	assign job_stall = (st_q != scc_pkg::ST_IDLE);
	assign out_valid = (st_q == scc_pkg::ST_DONE);

	// operands of the current 48x48 product
	always_comb begin
		ma = mag_q; mb = mag_q;
		case (step_q)
			4'd1:    begin ma = xx_q; mb = yy_q; end
			default: begin ma = mag_q; mb = mag_q; end
		endcase
		fa = pp_q[0] ? ma[47:24] : ma[23:0];
		fb = pp_q[1] ? mb[47:24] : mb[23:0];
	end
	assign fp = fa * fb;

	assign cand = {1'b0, res_q} | (17'd1 << bit_q);
	assign k_n  = {cand[15:0], 1'b0} - 17'd1;

	// next state
	always_comb begin
		st_n = st_q;
		case (st_q)
			scc_pkg::ST_IDLE: if (job_valid) st_n = scc_pkg::ST_MUL;
			scc_pkg::ST_MUL:
				if (zero_q) st_n = scc_pkg::ST_DONE;
				else if (step_q == 4'd1 && pp_q == 3'd4) st_n = scc_pkg::ST_SRCH;
			scc_pkg::ST_SRCH: if (pp_q == 3'd4) st_n = scc_pkg::ST_CMP;
			scc_pkg::ST_CMP:  if (bit_q == 5'd0) st_n = scc_pkg::ST_DONE;
				else st_n = scc_pkg::ST_SRCH;
			scc_pkg::ST_DONE: if (!out_stall) st_n = scc_pkg::ST_IDLE;
			default: st_n = scc_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= scc_pkg::ST_IDLE;
		else         st_q <= st_n;
	end

	// datapath
	always_ff @(posedge clk) begin
		case (st_q)
			scc_pkg::ST_IDLE: begin
				mag_q   <= job_data.dot[47] ? 48'(-job_data.dot) : 48'(job_data.dot);
				neg_q   <= job_data.dot[47];
				xx_q    <= job_data.xx;
				yy_q    <= job_data.yy;
				empty_q <= job_data.empty;
				zero_q  <= job_data.empty || (job_data.xx == '0) || (job_data.yy == '0);
				step_q  <= 4'd0;
				pp_q    <= 3'd0;
				acc_q   <= '0;
				res_q   <= 16'd0;
				bit_q   <= 5'd16;
			end
			scc_pkg::ST_MUL: begin
				if (pp_q == 3'd4) begin
					if (step_q == 4'd0) mm_q <= acc_q;
					else                xy_q <= acc_q;
					acc_q  <= '0;
					pp_q   <= 3'd0;
					step_q <= step_q + 4'd1;
				end else begin
					acc_q <= acc_q + (96'(fp) << (24 * (32'(pp_q[0]) + 32'(pp_q[1]))));
					pp_q  <= pp_q + 3'd1;
				end
			end
			scc_pkg::ST_SRCH: begin
				// lhs = k^2 * xy, k^2 first then 34x96 over four chunks
				if (pp_q == 3'd0) begin
					kk_q  <= 34'(k_n * k_n);
					lhs_q <= '0;
					pp_q  <= 3'd1;
				end else begin
					lhs_q <= lhs_q + (128'(kk_q * xy_q[24*(32'(pp_q)-1) +: 24])
						<< (24 * (32'(pp_q) - 1)));
					pp_q  <= pp_q + 3'd1;
				end
			end
			scc_pkg::ST_CMP: begin
				if (cand <= 17'd32768 && lhs_q <= {mm_q, 32'd0})
					res_q <= cand[15:0];
				if (bit_q != 5'd0) bit_q <= bit_q - 5'd1;
				pp_q <= 3'd0;
			end
			default: ;
		endcase
	end

	// exactly +1 saturates, exactly -1 stays
	always_comb begin
		out_data.empty_selection = empty_q;
		if (zero_q)         out_data.coefficient = 16'sd0;
		else if (neg_q)     out_data.coefficient = -$signed(res_q);
		else if (res_q[15]) out_data.coefficient = 16'sh7FFF;
		else                out_data.coefficient = $signed(res_q);
	end

endmodule

// ===== tb/selective_cosine_correlation_tb.sv =====
// selective_cosine_correlation_tb: self-checking testbench for the cosine correlation block
// depends on scc_pkg and the selective_cosine_correlation rtl
`timescale 1ns / 100ps

// correlation predictor and store of expected coefficients
class corr_scoreboard;
	scc_pkg::mode_t      mode;
	longint              dot_acc;
	longint              xx_acc;
	longint              yy_acc;
	int                  pair_count;
	scc_pkg::out_beat_t  expected_q[$];
	int                  errors;

	function new();
		mode = scc_pkg::MODE_ALL;
		errors = 0;
		clear_sums();
	endfunction

	function void clear_sums();
		dot_acc = 0;
		xx_acc = 0;
		yy_acc = 0;
		pair_count = 0;
	endfunction

	function int pending();
		return expected_q.size();
	endfunction

	// nearest integer to 32768*|dot|/sqrt(xx*yy), halves up
	function int unsigned scaled_ratio(longint mag, longint xx, longint yy);
		logic [127:0] rhs;
		logic [127:0] xy;
		logic [127:0] lhs;
		logic [127:0] kk;
		int unsigned lo;
		int unsigned hi;
		int unsigned c;
		rhs = 128'(mag) * 128'(mag);
		rhs = rhs << 32;
		xy = 128'(xx) * 128'(yy);
		lo = 0;
		hi = 32768;
		while (lo < hi) begin
			c = (lo + hi + 1) >> 1;
			kk = 128'(2 * c - 1) * 128'(2 * c - 1);
			lhs = kk * xy;
			if (lhs <= rhs)
				lo = c;
			else
				hi = c - 1;
		end
		return lo;
	endfunction

	// note an accepted input beat and queue its result on a last pair
	function void note_input(scc_pkg::in_beat_t b);
		longint x;
		longint y;
		bit admit;
		longint mag;
		longint coef;
		scc_pkg::out_beat_t r;
		x = b.sample_x;
		y = b.sample_y;
		case (mode)
			scc_pkg::MODE_POS: admit = x > 0;
			scc_pkg::MODE_NEG: admit = x < 0;
			default: admit = 1;
		endcase
		if (admit && pair_count < 65536) begin
			dot_acc += x * y;
			xx_acc += x * x;
			yy_acc += y * y;
			pair_count++;
		end
		if (!b.last_sample)
			return;
		coef = 0;
		r.empty_selection = (pair_count == 0);
		if (pair_count != 0 && xx_acc != 0 && yy_acc != 0) begin
			mag = dot_acc < 0 ? -dot_acc : dot_acc;
			coef = scaled_ratio(mag, xx_acc, yy_acc);
			if (dot_acc < 0)
				coef = -coef;
			if (coef > 32767)
				coef = 32767;
		end
		r.coefficient = 16'(coef);
		expected_q.push_back(r);
		clear_sums();
	endfunction

	// compare one output beat with the oldest expectation
	function void check_result(scc_pkg::out_beat_t got);
		scc_pkg::out_beat_t want;
		if (expected_q.size() == 0) begin
			$display("%0t: unexpected result coefficient=%0d empty=%0d",
				$time, got.coefficient, got.empty_selection);
			errors++;
			return;
		end
		want = expected_q.pop_front();
		if (got.coefficient !== want.coefficient) begin
			$display("%0t: coefficient expected %0d actual %0d",
				$time, want.coefficient, got.coefficient);
			errors++;
		end
		if (got.empty_selection !== want.empty_selection) begin
			$display("%0t: empty_selection expected %0d actual %0d",
				$time, want.empty_selection, got.empty_selection);
			errors++;
		end
	endfunction
endclass

module selective_cosine_correlation_tb;

	localparam int IdleLimit = 4000;
	localparam int DrainCycles = 300;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	logic [1:0]          cfg_wdata = 2'd0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	scc_pkg::in_beat_t   in_data = '0;
	logic                out_valid;
	logic                out_stall = 1'b1;
	scc_pkg::out_beat_t  out_data;

	corr_scoreboard sb = new();
	int idle_cycles = 0;
	bit no_gaps = 0;
	bit no_stalls = 0;

	selective_cosine_correlation dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// result check at each accepted output beat
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(out_data);
	end

	// watchdog on cycles with no beat on either side
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IdleLimit) begin
			$display("selective_cosine_correlation: mismatch");
			$finish;
		end
	end

	// receiver: random stall before each result beat
	initial begin
		int n;
		forever begin
			n = no_stalls ? 0 : $urandom_range(0, 15);
			if (n > 0) begin
				@(negedge clk);
				out_stall <= 1'b1;
				repeat (n - 1) @(negedge clk);
			end
			@(negedge clk);
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	// one input beat, preceded by a gap of idle cycles
	task automatic send_beat(input logic signed [15:0] x, input logic signed [15:0] y,
			input logic last);
		scc_pkg::in_beat_t b;
		int gap;
		b.sample_x = x;
		b.sample_y = y;
		b.last_sample = last;
		gap = no_gaps ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= b;
		do @(posedge clk); while (in_stall);
		sb.note_input(b);
	endtask

	// hold the input until every result is back and the block has settled
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending() > 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic write_mode(input scc_pkg::mode_t m);
		settle();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.mode = m;
	endtask

	function automatic logic signed [15:0] rand_sample();
		case ($urandom_range(0, 5))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return 16'(int'($urandom_range(0, 8)) - 4);
			default: return 16'($urandom);
		endcase
	endfunction

	// random vectors: correlated, anti-correlated, noisy correlated or independent content
	task automatic random_vectors(input int items);
		int sent;
		int len;
		int kind;
		logic signed [15:0] x;
		logic signed [15:0] y;
		sent = 0;
		while (sent < items) begin
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
			kind = $urandom_range(0, 3);
			no_gaps = ($urandom_range(0, 4) == 0);
			no_stalls = ($urandom_range(0, 4) == 0);
			for (int i = 0; i < len; i++) begin
				x = rand_sample();
				case (kind)
					0: y = x;
					1: y = -x;
					2: y = x + 16'(int'($urandom_range(0, 64)) - 32);
					default: y = rand_sample();
				endcase
				send_beat(x, y, i == len - 1);
			end
			sent += len;
		end
		no_gaps = 0;
		no_stalls = 0;
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: saturation at +1, exact -1, zero denominators, empty selection
		write_mode(scc_pkg::MODE_ALL);
		send_beat(16'sh7fff, 16'sh7fff, 1'b0);
		send_beat(16'sh8000, 16'sh8000, 1'b1);
		send_beat(16'sh1234, -16'sh1234, 1'b0);
		send_beat(16'sh8000, 16'sh7fff, 1'b1);
		send_beat(16'sh7fff, 16'sh0000, 1'b0);
		send_beat(16'sh8000, 16'sh0000, 1'b1);
		send_beat(16'sh0000, 16'sh5555, 1'b1);
		send_beat(16'sh7fff, 16'sh8000, 1'b1);
		write_mode(scc_pkg::MODE_POS);
		send_beat(16'sh0000, 16'sh0100, 1'b0);
		send_beat(-16'sh0005, 16'sh0100, 1'b1);
		send_beat(16'sh0003, 16'sh0004, 1'b0);
		send_beat(-16'sh0003, 16'sh0004, 1'b0);
		send_beat(16'sh0004, -16'sh0003, 1'b1);
		write_mode(scc_pkg::MODE_NEG);
		send_beat(16'sh0000, 16'sh0100, 1'b0);
		send_beat(16'sh0007, 16'sh0100, 1'b1);
		send_beat(-16'sh0002, 16'sh0009, 1'b0);
		send_beat(16'sh0002, 16'sh0009, 1'b1);
		random_vectors(480);
		write_mode(scc_pkg::MODE_ALT);
		send_beat(16'sh0000, 16'sh0001, 1'b0);
		send_beat(-16'sh0001, 16'sh0001, 1'b1);
		random_vectors(480);
		write_mode(scc_pkg::MODE_POS);
		random_vectors(480);
		write_mode(scc_pkg::MODE_ALL);
		random_vectors(480);

		settle();
		if (sb.errors == 0)
			$display("selective_cosine_correlation: match");
		else
			$display("selective_cosine_correlation: mismatch");
		$finish;
	end
endmodule
